>>> rtl/tasp_pkg.sv
package tasp_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QADDR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] KIND_NAME   = 3'd0;
  localparam logic [2:0] KIND_PREFIX = 3'd1;
  localparam logic [2:0] KIND_ENTRY  = 3'd2;
  localparam logic [2:0] KIND_DATA   = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  localparam logic [1:0] TYPE_DIR   = 2'd0;
  localparam logic [1:0] TYPE_REG   = 2'd1;
  localparam logic [1:0] TYPE_OTHER = 2'd2;

  localparam logic [1:0] SIZE_OCTAL   = 2'd0;
  localparam logic [1:0] SIZE_STOPPED = 2'd1;
  localparam logic [1:0] SIZE_B256    = 2'd2;

  localparam logic [8:0] OFF_NAME_END   = 9'd100;
  localparam logic [8:0] OFF_SIZE       = 9'd124;
  localparam logic [8:0] OFF_SIZE_END   = 9'd136;
  localparam logic [8:0] OFF_TYPE       = 9'd156;
  localparam logic [8:0] OFF_PREFIX     = 9'd345;
  localparam logic [8:0] OFF_PREFIX_END = 9'd500;
  localparam logic [8:0] OFF_LAST       = 9'd511;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_DIR   = 8'h35;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_value;
    logic [1:0]  entry_type;
    logic [63:0] entry_size;
    logic        last_data;
    logic        truncated;
  } result_t;

  // one decoded byte: an optional main result, then an optional archive end
  typedef struct packed {
    logic    has_main;
    result_t main;
    logic    has_end;
    logic    end_trunc;
  } entry_t;

  function automatic result_t end_result(input logic trunc);
    result_t r;
    r = '0;
    r.kind = KIND_END;
    r.truncated = trunc;
    return r;
  endfunction

endpackage

>>> rtl/tar_archive_stream_parser.sv
// Channel   Request            Payload
// input     push / full        archive_byte, end_of_input
// result    pop / empty        kind, char_value, entry_type, entry_size, last_data, truncated
//
// One byte is taken per cycle unless full; header decode and content counting are combinational.
// Each byte's results pass through a slot of a four-deep queue, then the output register;
// results leave at one per cycle while pop is high.
// full rises only when the queue holds four undrained groups, i.e. when pop is held low.
// rst is synchronous and clears parser state, queue count and pointers, and output valid flag.
module tar_archive_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  archive_byte,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [7:0]  char_value,
  output logic [1:0]  entry_type,
  output logic [63:0] entry_size,
  output logic        last_data,
  output logic        truncated
);
  import tasp_pkg::*;

  logic    q_full;
  logic    q_push;
  entry_t  q_wdata;
  logic    q_pop;
  entry_t  q_rdata;
  logic    q_valid;
  result_t result;

  tasp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .archive_byte (archive_byte),
    .end_of_input (end_of_input),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  tasp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  tasp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  assign full = q_full;
  assign kind = result.kind;
  assign char_value = result.char_value;
  assign entry_type = result.entry_type;
  assign entry_size = result.entry_size;
  assign last_data = result.last_data;
  assign truncated = result.truncated;

endmodule

>>> rtl/tasp_front.sv
module tasp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [7:0]      archive_byte,
  input  logic            end_of_input,
  input  logic            q_full,
  output logic            q_push,
  output tasp_pkg::entry_t q_data
);
  import tasp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_CONTENT = 3'b010,
    PH_DONE    = 3'b100
  } phase_t;

  phase_t      phase, phase_next;
  logic [8:0]  record_offset, record_offset_next;
  logic [63:0] data_left, data_left_next;
  logic [63:0] size_accum, size_accum_next;
  logic [1:0]  size_mode, size_mode_next;
  logic        name_open, name_open_next;
  logic        prefix_open, prefix_open_next;
  logic [1:0]  current_type, current_type_next;
  logic        fire;
  entry_t      ent;

  assign fire = push & ~q_full;

  always_comb begin
    phase_next = phase;
    record_offset_next = record_offset;
    data_left_next = data_left;
    size_accum_next = size_accum;
    size_mode_next = size_mode;
    name_open_next = name_open;
    prefix_open_next = prefix_open;
    current_type_next = current_type;
    ent = '0;
    if (fire) begin
      case (phase)
        PH_HEADER: begin
          if (record_offset == 9'd0) begin
            name_open_next = 1'b1;
            prefix_open_next = 1'b1;
            size_accum_next = '0;
            size_mode_next = SIZE_OCTAL;
          end
          if (record_offset == 9'd0 && archive_byte == 8'd0) begin
            phase_next = PH_DONE;
            ent.has_main = 1'b1;
            ent.main = end_result(1'b0);
          end else begin
            record_offset_next = record_offset + 9'd1;
            if (record_offset < OFF_NAME_END) begin
              if (archive_byte == 8'd0) begin
                name_open_next = 1'b0;
              end else if (name_open_next) begin
                ent.has_main = 1'b1;
                ent.main.kind = KIND_NAME;
                ent.main.char_value = archive_byte;
              end
            end else if (record_offset >= OFF_PREFIX && record_offset < OFF_PREFIX_END) begin
              if (archive_byte == 8'd0) begin
                prefix_open_next = 1'b0;
              end else if (prefix_open_next) begin
                ent.has_main = 1'b1;
                ent.main.kind = KIND_PREFIX;
                ent.main.char_value = archive_byte;
              end
            end else if (record_offset >= OFF_SIZE && record_offset < OFF_SIZE_END) begin
              if (record_offset == OFF_SIZE && archive_byte[7]) begin
                size_mode_next = SIZE_B256;
                size_accum_next = {57'd0, archive_byte[6:0]};
              end else if (size_mode_next == SIZE_B256) begin
                size_accum_next = {size_accum_next[55:0], archive_byte};
              end else if (size_mode_next == SIZE_OCTAL) begin
                if (archive_byte >= CHAR_ZERO && archive_byte <= CHAR_SEVEN) begin
                  size_accum_next = {size_accum_next[60:0], archive_byte[2:0]};
                end else begin
                  size_mode_next = SIZE_STOPPED;
                end
              end
            end else if (record_offset == OFF_TYPE) begin
              if (archive_byte == CHAR_DIR) begin
                current_type_next = TYPE_DIR;
              end else if (archive_byte == CHAR_ZERO || archive_byte == 8'd0) begin
                current_type_next = TYPE_REG;
              end else begin
                current_type_next = TYPE_OTHER;
              end
            end else if (record_offset == OFF_LAST) begin
              ent.has_main = 1'b1;
              ent.main.kind = KIND_ENTRY;
              ent.main.entry_type = current_type;
              ent.main.entry_size = size_accum;
              data_left_next = size_accum;
              if (size_accum != 64'd0) begin
                phase_next = PH_CONTENT;
              end
            end
          end
        end
        PH_CONTENT: begin
          if (data_left != 64'd0) begin
            data_left_next = data_left - 64'd1;
            if (current_type == TYPE_REG) begin
              ent.has_main = 1'b1;
              ent.main.kind = KIND_DATA;
              ent.main.char_value = archive_byte;
              ent.main.last_data = (data_left == 64'd1);
            end
          end
          record_offset_next = record_offset + 9'd1;
          if (record_offset_next == 9'd0 && data_left_next == 64'd0) begin
            phase_next = PH_HEADER;
          end
        end
        default: begin
        end
      endcase
      if (end_of_input && phase_next != PH_DONE) begin
        ent.has_end = 1'b1;
        ent.end_trunc = ~(phase_next == PH_HEADER && record_offset_next == 9'd0);
        phase_next = PH_DONE;
      end
    end
  end

  assign q_push = ent.has_main | ent.has_end;
  assign q_data = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      record_offset <= '0;
      data_left <= '0;
      size_accum <= '0;
      size_mode <= SIZE_OCTAL;
      name_open <= 1'b1;
      prefix_open <= 1'b1;
      current_type <= TYPE_DIR;
    end else begin
      phase <= phase_next;
      record_offset <= record_offset_next;
      data_left <= data_left_next;
      size_accum <= size_accum_next;
      size_mode <= size_mode_next;
      name_open <= name_open_next;
      prefix_open <= prefix_open_next;
      current_type <= current_type_next;
    end
  end

endmodule

>>> rtl/tasp_queue.sv
module tasp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tasp_pkg::entry_t wdata,
  output logic             full,
  input  logic             pop,
  output tasp_pkg::entry_t rdata,
  output logic             valid
);
  import tasp_pkg::*;

  entry_t              slots [QDEPTH];
  logic [QADDR_W-1:0]  wr_ptr;
  logic [QADDR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full = (count == QCNT_W'(QDEPTH));
  assign valid = (count != '0);
  assign rdata = slots[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop = pop & valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QADDR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QADDR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/tasp_back.sv
module tasp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  tasp_pkg::entry_t  q_data,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output tasp_pkg::result_t result
);
  import tasp_pkg::*;

  logic    out_valid;
  result_t out_reg;
  logic    pend_end;
  logic    pend_trunc;
  logic    can_load;

  assign can_load = ~out_valid | pop;
  assign q_pop = can_load & ~pend_end & q_valid;
  assign empty = ~out_valid;
  assign result = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_end <= 1'b0;
      pend_trunc <= 1'b0;
    end else if (can_load) begin
      if (pend_end) begin
        out_valid <= 1'b1;
        out_reg <= end_result(pend_trunc);
        pend_end <= 1'b0;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        if (q_data.has_main) begin
          out_reg <= q_data.main;
          pend_end <= q_data.has_end;
          pend_trunc <= q_data.end_trunc;
        end else begin
          out_reg <= end_result(q_data.end_trunc);
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/tasp_checker.sv
module tasp_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  kind,
  input logic [7:0]  char_value,
  input logic [63:0] entry_size
);
  import tasp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(char_value)))
    else $error("waiting result changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (kind <= KIND_END))
    else $error("kind code out of range");

  a_size_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_ENTRY) |-> (entry_size == 64'd0))
    else $error("entry_size set on non-entry result");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && kind == KIND_END) |=> empty)
    else $error("result after archive end");

endmodule

bind tar_archive_stream_parser tasp_checker u_tasp_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .kind       (kind),
  .char_value (char_value),
  .entry_size (entry_size)
);
